[rtl/iee_pkg.sv]
// ----------------------------------------------------------------------------
// iee_pkg
// Types, constants and helper functions shared by the expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

  localparam int StackDepth    = 16;
  localparam int SpW           = $clog2(StackDepth);
  localparam int CntW          = SpW + 1;
  localparam int FracBits      = 32;
  localparam int MaxFracDigits = 18;
  localparam int FdW           = 5;
  localparam int ValW          = 64;
  localparam int DivW          = 2 * ValW;
  localparam int DivCntW       = $clog2(DivW);

  localparam logic [ValW-1:0] SignBit = {1'b1, {(ValW-1){1'b0}}};
  localparam logic [ValW-1:0] PosMax  = {1'b0, {(ValW-1){1'b1}}};

  localparam logic [15:0] CharZero   = 16'h0030;
  localparam logic [15:0] CharNine   = 16'h0039;
  localparam logic [15:0] CharDot    = 16'h002E;
  localparam logic [15:0] CharPlus   = 16'h002B;
  localparam logic [15:0] CharMinus  = 16'h002D;
  localparam logic [15:0] CharTimes  = 16'h00D7;
  localparam logic [15:0] CharDivide = 16'h00F7;
  localparam logic [15:0] CharLPar   = 16'h0028;
  localparam logic [15:0] CharRPar   = 16'h0029;

  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatFault  = 2'd1;
  localparam logic [1:0] StatDivZ   = 2'd2;
  localparam logic [1:0] StatSat    = 2'd3;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_LPAR = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    TK_DIGIT,
    TK_DOT,
    TK_OP,
    TK_LPAR,
    TK_RPAR,
    TK_SKIP
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    op_t        op;
    logic [3:0] digit;
    logic       last;
  } token_t;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic            sat;
  } sat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TOKEN,
    ST_FIN,
    ST_DIVW,
    ST_PUSH,
    ST_OPER,
    ST_LAST,
    ST_RED,
    ST_RDB,
    ST_RDA,
    ST_EXEC,
    ST_MUL,
    ST_MULF,
    ST_OUT,
    ST_EMIT
  } state_t;

  function automatic logic [1:0] rank(input op_t op);
    logic [1:0] r;
    case (op)
      OP_MUL, OP_DIV: r = 2'd2;
      OP_ADD, OP_SUB: r = 2'd1;
      default:        r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [ValW-1:0] magnitude(input logic [ValW-1:0] v);
    return v[ValW-1] ? (ValW'(0) - v) : v;
  endfunction

  function automatic sat_t saturate(input logic neg, input logic [ValW-1:0] mag,
                                    input logic ovf);
    sat_t s;
    if (!neg) begin
      s.sat   = ovf || mag[ValW-1];
      s.value = s.sat ? PosMax : mag;
    end else begin
      s.sat   = ovf || (mag > SignBit);
      s.value = s.sat ? SignBit : (ValW'(0) - mag);
    end
    return s;
  endfunction

  function automatic logic [ValW-1:0] pow10(input logic [FdW-1:0] n);
    logic [ValW-1:0] p;
    case (n)
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      5'd10:   p = 64'd10000000000;
      5'd11:   p = 64'd100000000000;
      5'd12:   p = 64'd1000000000000;
      5'd13:   p = 64'd10000000000000;
      5'd14:   p = 64'd100000000000000;
      5'd15:   p = 64'd1000000000000000;
      5'd16:   p = 64'd10000000000000000;
      5'd17:   p = 64'd100000000000000000;
      5'd18:   p = 64'd1000000000000000000;
      default: p = 64'd1;
    endcase
    return p;
  endfunction

endpackage

[rtl/iee_ifs.sv]
// ----------------------------------------------------------------------------
// iee channel interfaces
// Valid/ready channels for input characters and evaluated results.
// ----------------------------------------------------------------------------
interface iee_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] char_code;
  logic        last_char;
  modport source (output valid, char_code, last_char, input ready);
  modport sink   (input valid, char_code, last_char, output ready);
endinterface

interface iee_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result_value;
  logic [1:0]         status;
  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

[rtl/infix_expression_evaluator_unit.sv]
// ----------------------------------------------------------------------------
// infix_expression_evaluator_unit
// Shunting-yard evaluator of infix expressions, one UTF-16 character at a time.
// ----------------------------------------------------------------------------
// A two-entry token queue sits between the character classifier and the
// sequencer, so characters are taken while earlier ones are still evaluated.
// The sequencer adds a digit or dot to the number being built; the end of
// a number starts the decimal to Q32.32 conversion on the one-bit-per-cycle
// divider (128 steps, a rounding step) and the push; a malformed number
// pushes zero. A reduction reads both operands and adds, subtracts,
// multiplies or divides (the same divider); a left bracket or an operator
// without operands is dropped. The last character adds the final reductions
// and the read-out of the result, which then waits in an output register
// until taken. The stacks hold 16 values and 16 operators.
module infix_expression_evaluator_unit (
  input  logic      clk,
  input  logic      rst,
  iee_in_if.sink    char_in,
  iee_out_if.source result_out
);

  logic            tok_valid;
  logic            tok_pop;
  iee_pkg::token_t tok;

  iee_front u_front (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_in),
    .tok_valid (tok_valid),
    .tok       (tok),
    .tok_pop   (tok_pop)
  );

  iee_back u_back (
    .clk        (clk),
    .rst        (rst),
    .tok_valid  (tok_valid),
    .tok_in     (tok),
    .tok_pop    (tok_pop),
    .result_out (result_out)
  );

endmodule

[rtl/iee_ram.sv]
// ----------------------------------------------------------------------------
// iee_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module iee_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/iee_front.sv]
// ----------------------------------------------------------------------------
// iee_front
// Classifies incoming characters into tokens and queues them for the back end.
// ----------------------------------------------------------------------------
module iee_front (
  input  logic             clk,
  input  logic             rst,
  iee_in_if.sink           char_in,
  output logic             tok_valid,
  output iee_pkg::token_t  tok,
  input  logic             tok_pop
);

  iee_pkg::token_t cls;
  iee_pkg::token_t q [2];
  logic            wp;
  logic            rp;
  logic [1:0]      cnt;
  logic            push;
  logic            pop;

  always_comb begin
    cls.kind  = iee_pkg::TK_SKIP;
    cls.op    = iee_pkg::OP_NONE;
    cls.digit = char_in.char_code[3:0];
    cls.last  = char_in.last_char;
    if (char_in.char_code >= iee_pkg::CharZero && char_in.char_code <= iee_pkg::CharNine) begin
      cls.kind = iee_pkg::TK_DIGIT;
    end else begin
      unique case (char_in.char_code)
        iee_pkg::CharDot:    cls.kind = iee_pkg::TK_DOT;
        iee_pkg::CharLPar:   cls.kind = iee_pkg::TK_LPAR;
        iee_pkg::CharRPar:   cls.kind = iee_pkg::TK_RPAR;
        iee_pkg::CharPlus: begin
          cls.kind = iee_pkg::TK_OP;
          cls.op   = iee_pkg::OP_ADD;
        end
        iee_pkg::CharMinus: begin
          cls.kind = iee_pkg::TK_OP;
          cls.op   = iee_pkg::OP_SUB;
        end
        iee_pkg::CharTimes: begin
          cls.kind = iee_pkg::TK_OP;
          cls.op   = iee_pkg::OP_MUL;
        end
        iee_pkg::CharDivide: begin
          cls.kind = iee_pkg::TK_OP;
          cls.op   = iee_pkg::OP_DIV;
        end
        default: cls.kind = iee_pkg::TK_SKIP;
      endcase
    end
  end

  assign char_in.ready = (cnt != 2'd2);
  assign tok_valid     = (cnt != 2'd0);
  assign tok           = q[rp];
  assign push          = char_in.valid && char_in.ready;
  assign pop           = tok_pop && tok_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= cls;
    end
  end

endmodule

[rtl/iee_divider.sv]
// ----------------------------------------------------------------------------
// iee_divider
// Restoring divider, one quotient bit per cycle, round to nearest ties up.
// ----------------------------------------------------------------------------
module iee_divider (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [iee_pkg::DivW-1:0] dividend,
  input  logic [iee_pkg::ValW-1:0] divisor,
  output logic                     done,
  output logic [iee_pkg::ValW-1:0] quotient,
  output logic                     ovf
);

  logic                        busy;
  logic                        rnd;
  logic [iee_pkg::DivCntW-1:0] cnt;
  logic [iee_pkg::DivW-1:0]    num;
  logic [iee_pkg::ValW-1:0]    den;
  logic [iee_pkg::ValW-1:0]    rem;
  logic [iee_pkg::ValW:0]      rem_sh;
  logic [iee_pkg::ValW:0]      rem_sub;
  logic                        ge;

  assign rem_sh  = {rem, num[iee_pkg::DivW-1]};
  assign rem_sub = rem_sh - {1'b0, den};
  assign ge      = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rnd  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rnd  <= 1'b0;
      end else if (busy && !rnd) begin
        if (cnt == {iee_pkg::DivCntW{1'b1}}) begin
          rnd <= 1'b1;
        end
      end else if (busy) begin
        busy <= 1'b0;
        rnd  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num      <= dividend;
      den      <= divisor;
      rem      <= '0;
      quotient <= '0;
      ovf      <= 1'b0;
      cnt      <= '0;
    end else if (busy && !rnd) begin
      rem      <= ge ? rem_sub[iee_pkg::ValW-1:0] : rem_sh[iee_pkg::ValW-1:0];
      ovf      <= ovf | quotient[iee_pkg::ValW-1];
      quotient <= {quotient[iee_pkg::ValW-2:0], ge};
      num      <= {num[iee_pkg::DivW-2:0], 1'b0};
      cnt      <= cnt + 1'b1;
    end else if (busy) begin
      // round half up on the remainder
      if (rem >= den - rem) begin
        if (&quotient) begin
          ovf <= 1'b1;
        end
        quotient <= quotient + 1'b1;
      end
    end
  end

endmodule

[rtl/iee_back.sv]
// ----------------------------------------------------------------------------
// iee_back
// Sequencer that builds numbers, runs the two stacks and the arithmetic.
// ----------------------------------------------------------------------------
module iee_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            tok_valid,
  input  iee_pkg::token_t tok_in,
  output logic            tok_pop,
  iee_out_if.source       result_out
);

  localparam int VW = iee_pkg::ValW;
  localparam int FB = iee_pkg::FracBits;

  iee_pkg::state_t state, state_next, ret;
  iee_pkg::token_t tok;

  logic [VW-1:0]            mant;
  logic [iee_pkg::FdW-1:0]  fd;
  logic                     nf_in, nf_dot, nf_bad;
  logic [iee_pkg::CntW-1:0] vc, opc, vc_m1, vc_m2, opc_m1;
  iee_pkg::op_t             ops [iee_pkg::StackDepth];
  iee_pkg::op_t             top_op, cur_op;
  logic [1:0]               sticky;
  logic [VW-1:0]            a, b, res;
  logic                     neg;
  logic [VW-1:0]            mx, my, pp;
  logic [1:0]               psh;
  logic [2:0]               mcnt;
  logic [2*VW-1:0]          acc, pp_sh;
  logic                     out_valid;
  logic [VW-1:0]            out_value;
  logic [1:0]               out_status;

  logic                     ram_we, ram_re;
  logic [iee_pkg::SpW-1:0]  ram_raddr;
  logic [VW-1:0]            rdata;

  logic                     div_start, div_done, div_ovf;
  logic [iee_pkg::DivW-1:0] div_dividend;
  logic [VW-1:0]            div_divisor, div_q;

  logic [VW+3:0]            m10;
  logic                     opc_full, vc_full;
  logic                     reduce_now;
  logic [VW-1:0]            add_r, add_sb, add_res;
  logic                     add_ovf;
  logic [VW-1:0]            mul_r;
  logic                     mul_ovf;
  logic [31:0]              mxs, mys;
  iee_pkg::sat_t            div_sat, mul_sat;

  function automatic logic [1:0] first_flag(input logic [1:0] cur, input logic [1:0] s);
    return (cur == iee_pkg::StatOk) ? s : cur;
  endfunction

  assign vc_m1    = vc - iee_pkg::CntW'(1);
  assign vc_m2    = vc - iee_pkg::CntW'(2);
  assign opc_m1   = opc - iee_pkg::CntW'(1);
  assign top_op   = ops[opc_m1[iee_pkg::SpW-1:0]];
  assign opc_full = opc[iee_pkg::CntW-1];
  assign vc_full  = vc[iee_pkg::CntW-1];
  assign m10      = ({4'b0, mant} << 3) + ({4'b0, mant} << 1) + (VW + 4)'(tok.digit);

  // pending operator on the stack that must reduce before this token
  always_comb begin
    reduce_now = 1'b0;
    if (opc != '0 && top_op != iee_pkg::OP_LPAR) begin
      if (tok.kind == iee_pkg::TK_RPAR) begin
        reduce_now = 1'b1;
      end else if (tok.kind == iee_pkg::TK_OP) begin
        reduce_now = iee_pkg::rank(top_op) >= iee_pkg::rank(tok.op);
      end
    end
  end

  always_comb begin
    add_r   = (cur_op == iee_pkg::OP_SUB) ? a - b : a + b;
    add_sb  = (cur_op == iee_pkg::OP_SUB) ? (b ^ iee_pkg::SignBit) : b;
    add_ovf = !(a[VW-1] ^ add_sb[VW-1]) && (add_r[VW-1] ^ a[VW-1]);
    add_res = add_ovf ? (a[VW-1] ? iee_pkg::SignBit : iee_pkg::PosMax) : add_r;
  end

  // partial products: low*low, low*high, high*low, high*high
  always_comb begin
    mxs = mcnt[1] ? mx[VW-1:32] : mx[31:0];
    mys = (mcnt[1:0] == 2'd1 || mcnt[1:0] == 2'd3) ? my[VW-1:32] : my[31:0];
    case (psh)
      2'd1:    pp_sh = {32'b0, pp, 32'b0};
      2'd2:    pp_sh = {pp, 64'b0};
      default: pp_sh = {64'b0, pp};
    endcase
  end

  always_comb begin
    mul_r   = acc[FB+VW-1:FB];
    mul_ovf = |acc[2*VW-1:FB+VW];
    if (acc[FB-1]) begin
      if (&mul_r) begin
        mul_ovf = 1'b1;
      end
      mul_r = mul_r + 1'b1;
    end
  end

  assign mul_sat = iee_pkg::saturate(neg, mul_r, mul_ovf);
  assign div_sat = iee_pkg::saturate(neg, div_q, div_ovf);

  always_comb begin
    if (state == iee_pkg::ST_FIN) begin
      div_dividend = {{(iee_pkg::DivW-VW-FB){1'b0}}, mant, {FB{1'b0}}};
      div_divisor  = iee_pkg::pow10(fd);
    end else begin
      div_dividend = {{(iee_pkg::DivW-VW-FB){1'b0}}, iee_pkg::magnitude(a), {FB{1'b0}}};
      div_divisor  = iee_pkg::magnitude(b);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      iee_pkg::ST_IDLE:  if (tok_valid) state_next = iee_pkg::ST_TOKEN;
      iee_pkg::ST_TOKEN: begin
        if (tok.kind == iee_pkg::TK_DIGIT || tok.kind == iee_pkg::TK_DOT) begin
          state_next = tok.last ? iee_pkg::ST_FIN : iee_pkg::ST_IDLE;
        end else begin
          state_next = iee_pkg::ST_FIN;
        end
      end
      iee_pkg::ST_FIN: begin
        if (nf_in && nf_bad)  state_next = iee_pkg::ST_PUSH;
        else if (nf_in)       state_next = iee_pkg::ST_DIVW;
        else                  state_next = iee_pkg::ST_OPER;
      end
      iee_pkg::ST_DIVW:  if (div_done) state_next = iee_pkg::ST_PUSH;
      iee_pkg::ST_PUSH:  state_next = ret;
      iee_pkg::ST_OPER:  state_next = reduce_now ? iee_pkg::ST_RED : iee_pkg::ST_LAST;
      iee_pkg::ST_LAST: begin
        if (!tok.last)       state_next = iee_pkg::ST_IDLE;
        else if (opc != '0)  state_next = iee_pkg::ST_RED;
        else                 state_next = iee_pkg::ST_OUT;
      end
      iee_pkg::ST_RED: begin
        if (top_op == iee_pkg::OP_LPAR || vc < iee_pkg::CntW'(2)) state_next = ret;
        else                                                    state_next = iee_pkg::ST_RDB;
      end
      iee_pkg::ST_RDB:   state_next = iee_pkg::ST_RDA;
      iee_pkg::ST_RDA:   state_next = iee_pkg::ST_EXEC;
      iee_pkg::ST_EXEC: begin
        case (cur_op)
          iee_pkg::OP_MUL: state_next = iee_pkg::ST_MUL;
          iee_pkg::OP_DIV: state_next = (b == '0) ? iee_pkg::ST_PUSH : iee_pkg::ST_DIVW;
          default:         state_next = iee_pkg::ST_PUSH;
        endcase
      end
      iee_pkg::ST_MUL:   if (mcnt == 3'd4) state_next = iee_pkg::ST_MULF;
      iee_pkg::ST_MULF:  state_next = iee_pkg::ST_PUSH;
      iee_pkg::ST_OUT:   state_next = iee_pkg::ST_EMIT;
      iee_pkg::ST_EMIT:  if (!out_valid || result_out.ready) state_next = iee_pkg::ST_IDLE;
      default:           state_next = iee_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    tok_pop   = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = vc_m1[iee_pkg::SpW-1:0];
    div_start = 1'b0;
    unique case (state)
      iee_pkg::ST_IDLE: tok_pop = tok_valid;
      iee_pkg::ST_FIN:  div_start = nf_in && !nf_bad;
      iee_pkg::ST_PUSH: ram_we = !vc_full;
      iee_pkg::ST_RED:  ram_re = top_op != iee_pkg::OP_LPAR && vc >= iee_pkg::CntW'(2);
      iee_pkg::ST_RDB: begin
        ram_re    = 1'b1;
        ram_raddr = vc_m2[iee_pkg::SpW-1:0];
      end
      iee_pkg::ST_EXEC: div_start = (cur_op == iee_pkg::OP_DIV) && (b != '0);
      iee_pkg::ST_OUT:  ram_re = vc != '0;
      default: ;
    endcase
  end

  iee_ram #(.Width(VW), .Depth(iee_pkg::StackDepth)) u_values (
    .clk   (clk),
    .we    (ram_we),
    .waddr (vc[iee_pkg::SpW-1:0]),
    .wdata (res),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  iee_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q),
    .ovf      (div_ovf)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= iee_pkg::ST_IDLE;
      ret       <= iee_pkg::ST_OPER;
      vc        <= '0;
      opc       <= '0;
      sticky    <= iee_pkg::StatOk;
      nf_in     <= 1'b0;
      nf_dot    <= 1'b0;
      nf_bad    <= 1'b0;
      fd        <= '0;
      mant      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == iee_pkg::ST_EMIT && (!out_valid || result_out.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && result_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        iee_pkg::ST_TOKEN: begin
          if (tok.kind == iee_pkg::TK_DIGIT) begin
            nf_in <= 1'b1;
            if (!nf_dot || fd < iee_pkg::FdW'(iee_pkg::MaxFracDigits)) begin
              if (m10[VW+3:VW] != 4'd0) begin
                sticky <= first_flag(sticky, iee_pkg::StatSat);
                mant   <= '1;
              end else begin
                mant <= m10[VW-1:0];
              end
              if (nf_dot) begin
                fd <= fd + 1'b1;
              end
            end
          end else if (tok.kind == iee_pkg::TK_DOT) begin
            if (nf_dot) begin
              nf_bad <= 1'b1;
            end
            nf_in  <= 1'b1;
            nf_dot <= 1'b1;
          end
        end
        iee_pkg::ST_FIN: begin
          nf_in  <= 1'b0;
          nf_dot <= 1'b0;
          nf_bad <= 1'b0;
          fd     <= '0;
          mant   <= '0;
          ret    <= iee_pkg::ST_OPER;
        end
        iee_pkg::ST_DIVW: begin
          if (div_done && div_sat.sat) begin
            sticky <= first_flag(sticky, iee_pkg::StatSat);
          end
        end
        iee_pkg::ST_PUSH: begin
          if (vc_full) begin
            sticky <= first_flag(sticky, iee_pkg::StatFault);
          end else begin
            vc <= vc + 1'b1;
          end
        end
        iee_pkg::ST_OPER: begin
          if (reduce_now) begin
            ret <= iee_pkg::ST_OPER;
          end else if (tok.kind == iee_pkg::TK_RPAR) begin
            if (opc != '0) begin
              opc <= opc_m1;
            end
          end else if (tok.kind == iee_pkg::TK_LPAR || tok.kind == iee_pkg::TK_OP) begin
            if (opc_full) begin
              sticky <= first_flag(sticky, iee_pkg::StatFault);
            end else begin
              opc <= opc + 1'b1;
            end
          end
        end
        iee_pkg::ST_LAST: ret <= iee_pkg::ST_LAST;
        iee_pkg::ST_RED: begin
          opc <= opc_m1;
          if (top_op != iee_pkg::OP_LPAR && vc < iee_pkg::CntW'(2)) begin
            sticky <= first_flag(sticky, iee_pkg::StatFault);
          end
        end
        iee_pkg::ST_RDA: vc <= vc_m2;
        iee_pkg::ST_EXEC: begin
          if ((cur_op == iee_pkg::OP_ADD || cur_op == iee_pkg::OP_SUB) && add_ovf) begin
            sticky <= first_flag(sticky, iee_pkg::StatSat);
          end else if (cur_op == iee_pkg::OP_DIV && b == '0) begin
            sticky <= first_flag(sticky, iee_pkg::StatDivZ);
          end
        end
        iee_pkg::ST_MULF: begin
          if (mul_sat.sat) begin
            sticky <= first_flag(sticky, iee_pkg::StatSat);
          end
        end
        iee_pkg::ST_EMIT: begin
          if (!out_valid || result_out.ready) begin
            vc     <= '0;
            opc    <= '0;
            sticky <= iee_pkg::StatOk;
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    unique case (state)
      iee_pkg::ST_IDLE: if (tok_valid) tok <= tok_in;
      iee_pkg::ST_FIN: begin
        neg <= 1'b0;
        res <= '0;
      end
      iee_pkg::ST_DIVW: if (div_done) res <= div_sat.value;
      iee_pkg::ST_OPER: begin
        if (!reduce_now && !opc_full) begin
          if (tok.kind == iee_pkg::TK_LPAR) begin
            ops[opc[iee_pkg::SpW-1:0]] <= iee_pkg::OP_LPAR;
          end else if (tok.kind == iee_pkg::TK_OP) begin
            ops[opc[iee_pkg::SpW-1:0]] <= tok.op;
          end
        end
      end
      iee_pkg::ST_RED: cur_op <= top_op;
      iee_pkg::ST_RDB: b <= rdata;
      iee_pkg::ST_RDA: a <= rdata;
      iee_pkg::ST_EXEC: begin
        res  <= (cur_op == iee_pkg::OP_DIV) ? '0 : add_res;
        neg  <= a[VW-1] ^ b[VW-1];
        mx   <= iee_pkg::magnitude(a);
        my   <= iee_pkg::magnitude(b);
        mcnt <= '0;
        acc  <= '0;
      end
      iee_pkg::ST_MUL: begin
        if (mcnt != 3'd4) begin
          pp  <= {32'b0, mxs} * {32'b0, mys};
          psh <= 2'(mcnt[1]) + 2'(mcnt[0]);
        end
        if (mcnt != 3'd0) begin
          acc <= acc + pp_sh;
        end
        mcnt <= mcnt + 1'b1;
      end
      iee_pkg::ST_MULF: res <= mul_sat.value;
      iee_pkg::ST_EMIT: begin
        if (!out_valid || result_out.ready) begin
          out_value  <= (vc == '0) ? '0 : rdata;
          out_status <= (vc == '0) ? first_flag(sticky, iee_pkg::StatFault) : sticky;
        end
      end
      default: ;
    endcase
  end

  assign result_out.valid        = out_valid;
  assign result_out.result_value = out_value;
  assign result_out.status       = out_status;

endmodule
